>>> rtl/core/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg: shared types for the sorted table binary search block
// Beat layouts, command codes and controller states.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 32;
    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = 11;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [INDEX_W-1:0]       entry_index;
        logic signed [KEY_W-1:0]  entry_value;
        logic signed [KEY_W-1:0]  search_key;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] position;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/core/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search: binary search over a loaded table
// Write beats load a dual-port table memory; search beats probe it at the
// upper midpoint and return a found flag and 1-based position.
// ----------------------------------------------------------------------------
//  channel | signals                      | beat
//  --------+------------------------------+------------------------------------
//  req     | req_valid, req_ready, req    | write entry or search key
//  rsp     | rsp_valid, rsp_ready, rsp    | found flag, position (searches only)
//  cfg     | cfg_we, cfg_data             | entry_count, no handshake
//
//  A write beat is taken in ST_IDLE. Each search probe reads the single table
//  read port into a register in ST_PROBE and compares in ST_CHECK; req_ready
//  stays low from the start of a search until it returns to ST_IDLE.
//  Reset clears control and entry_count; table contents stay undefined.
//  A result waiting on rsp does not block write beats; a finished search holds
//  in the controller until the response register is free.
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  stbs_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output stbs_pkg::rsp_t                      rsp,
    input  logic                                cfg_we,
    input  logic [stbs_pkg::COUNT_W-1:0]        cfg_data
);

    localparam int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CW          = stbs_pkg::COUNT_W;

    // table memory
    logic signed [stbs_pkg::KEY_W-1:0] mem [TABLE_DEPTH];
    logic signed [stbs_pkg::KEY_W-1:0] rdata_reg;
    logic                              mem_we;
    logic                              mem_re;
    logic [ADDR_W-1:0]                 mem_waddr;
    logic [ADDR_W-1:0]                 mem_raddr;

    stbs_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     eff_count;
    logic signed [CW:0]                low_reg, low_next;
    logic signed [CW:0]                high_reg, high_next;
    logic [CW-1:0]                     mid_reg, mid_next;
    logic [CW-1:0]                     mid;
    logic signed [CW+1:0]              mid_sum;
    logic signed [stbs_pkg::KEY_W-1:0] key_reg, key_next;
    logic                              found_reg, found_next;
    logic [CW-1:0]                     pos_reg, pos_next;
    logic                              rsp_valid_reg;
    stbs_pkg::rsp_t                    rsp_reg;

    logic req_fire;
    logic is_search;
    logic range_empty;
    logic hit;
    logic key_lt;
    logic rsp_load;

    assign req_fire  = req_valid && req_ready;
    assign is_search = (req.command == stbs_pkg::CMD_SEARCH);

    // a count beyond the table saturates to the depth
    assign eff_count = (int'(count_reg) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : count_reg;

    assign mid_sum     = {low_reg[CW], low_reg} + {high_reg[CW], high_reg} + (CW+2)'(1);
    assign mid         = mid_sum[CW:1];
    assign range_empty = (low_reg > high_reg);
    assign hit         = (rdata_reg == key_reg);
    assign key_lt      = (key_reg < rdata_reg);
    assign rsp_load    = (state_reg == stbs_pkg::ST_FINISH) && (!rsp_valid_reg || rsp_ready);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= req.entry_value;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                if (req_fire && is_search)
                begin
                    state_next = stbs_pkg::ST_PROBE;
                end
            end
            stbs_pkg::ST_PROBE:
            begin
                state_next = range_empty ? stbs_pkg::ST_FINISH : stbs_pkg::ST_CHECK;
            end
            stbs_pkg::ST_CHECK:
            begin
                state_next = hit ? stbs_pkg::ST_FINISH : stbs_pkg::ST_PROBE;
            end
            stbs_pkg::ST_FINISH:
            begin
                if (rsp_load)
                begin
                    state_next = stbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req_ready  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = ADDR_W'(req.entry_index);
        mem_raddr  = ADDR_W'(mid);
        low_next   = low_reg;
        high_next  = high_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                mem_we    = req_valid && !is_search && (int'(req.entry_index) < TABLE_DEPTH);
                if (req_valid && is_search)
                begin
                    low_next   = '0;
                    high_next  = $signed({1'b0, eff_count}) - (CW+1)'(1);
                    key_next   = req.search_key;
                    found_next = 1'b0;
                    pos_next   = '0;
                end
            end
            stbs_pkg::ST_PROBE:
            begin
                if (!range_empty)
                begin
                    mem_re   = 1'b1;
                    mid_next = mid;
                end
            end
            stbs_pkg::ST_CHECK:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    pos_next   = mid_reg + 1'b1;
                end
                else if (key_lt)
                begin
                    high_next = $signed({1'b0, mid_reg}) - (CW+1)'(1);
                end
                else
                begin
                    low_next = $signed({1'b0, mid_reg}) + (CW+1)'(1);
                end
            end
            stbs_pkg::ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stbs_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg   <= low_next;
        high_reg  <= high_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        if (rsp_load)
        begin
            rsp_reg.found    <= found_reg;
            rsp_reg.position <= pos_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a compare always follows a probe that issued a read
    a_check_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stbs_pkg::ST_PROBE && !range_empty) |=> (state_reg == stbs_pkg::ST_CHECK))
        else $error("compare state not entered after table read");

    // the search window never leaves the loaded range
    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stbs_pkg::ST_CHECK) |-> (mid_reg < eff_count))
        else $error("probe outside loaded entries");

    // a found result carries a nonzero position
    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.found == (rsp.position != '0)))
        else $error("found flag and position disagree");

    // a new response only loads when the previous one has gone
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("pending response overwritten");

endmodule
